FILE: hw/rtl/gpio_ctl_pkg.sv
// Shared types and constants of the GPIO mode, blink and latch controller.
package gpio_ctl_pkg;

  localparam int unsigned NUM_PINS = 40;
  localparam int unsigned PIN_W    = 6;
  localparam int unsigned PIN_SPAN = 2 ** PIN_W;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_W    = 40;

  typedef enum logic [2:0] {
    CMD_SET_INPUT = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_BLINK     = 3'd2,
    CMD_TICK      = 3'd3,
    CMD_SAMPLE    = 3'd4
  } cmd_e;

  typedef enum logic {
    REG_VALID_MASK = 1'b0,
    REG_THRESHOLD  = 1'b1
  } cfg_reg_e;

  localparam logic [2:0] MODE_FLOAT     = 3'd0;
  localparam logic [2:0] MODE_PULLUP    = 3'd1;
  localparam logic [2:0] MODE_PULLDOWN  = 3'd2;
  localparam logic [2:0] MODE_OUT_LOW   = 3'd3;
  localparam logic [2:0] MODE_OUT_HIGH  = 3'd4;
  localparam logic [2:0] MODE_BLINK_250 = 3'd5;
  localparam logic [2:0] MODE_BLINK_500 = 3'd6;

  localparam logic [1:0] LATCH_NONE = 2'd0;
  localparam logic [1:0] LATCH_LOW  = 2'd1;
  localparam logic [1:0] LATCH_HIGH = 2'd2;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;

  typedef struct packed {
    logic [2:0]          command;
    logic [PIN_W-1:0]    pin_index;
    logic [2:0]          sub_mode;
    logic [1:0]          latch_select;
    logic [1:0]          blink_phase;
    logic [NUM_PINS-1:0] pin_levels;
  } in_t;

  typedef struct packed {
    logic                status;
    logic [NUM_PINS-1:0] output_enable_mask;
    logic [NUM_PINS-1:0] output_level_mask;
    logic [NUM_PINS-1:0] pullup_mask;
    logic [NUM_PINS-1:0] pulldown_mask;
    logic [NUM_PINS-1:0] latched_mask;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

FILE: hw/rtl/gpio_ctl_fsm.sv
// Controller: accepts a transaction, sequences execution and the result strobe.
module gpio_ctl_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output gpio_ctl_pkg::ctl_t ctl_o
);
  import gpio_ctl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_q == ST_EXEC);
  assign done_o     = done_q;
  assign ctl_o.load = start && (state_q == ST_IDLE);
  assign ctl_o.exec = (state_q == ST_EXEC);

endmodule

FILE: hw/rtl/gpio_ctl_datapath.sv
// Datapath: configuration, per-pin state lanes and the result register.
module gpio_ctl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gpio_ctl_pkg::ctl_t                  ctl_i,
  input  gpio_ctl_pkg::in_t                   item_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [gpio_ctl_pkg::CFG_W-1:0]      cfg_wdata_i,
  output gpio_ctl_pkg::out_t                  result_o
);
  import gpio_ctl_pkg::*;

  in_t                 item_q;
  out_t                result_q;
  logic [NUM_PINS-1:0] valid_q;
  logic [CNT_W-1:0]    thr_q;

  logic [PIN_SPAN-1:0] valid_ext;
  logic                usable_pin;
  logic                arg_ok;
  logic                status_d;
  logic                apply;
  logic                is_tick;
  logic                is_sample;
  logic                l250;
  logic                l500;
  logic [NUM_PINS-1:0] oe_d, ol_d, pu_d, pd_d, la_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      thr_q   <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_VALID_MASK: valid_q <= cfg_wdata_i[NUM_PINS-1:0];
        REG_THRESHOLD:  thr_q   <= cfg_wdata_i[CNT_W-1:0];
        default:        valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= item_i;
    end
    if (ctl_i.exec) begin
      result_q.status             <= status_d;
      result_q.output_enable_mask <= oe_d;
      result_q.output_level_mask  <= ol_d;
      result_q.pullup_mask        <= pu_d;
      result_q.pulldown_mask      <= pd_d;
      result_q.latched_mask       <= la_d;
    end
  end

  assign valid_ext  = PIN_SPAN'(valid_q);
  assign usable_pin = (item_q.pin_index < PIN_W'(NUM_PINS)) && valid_ext[item_q.pin_index];

  always_comb begin
    arg_ok   = 1'b1;
    status_d = 1'b0;
    case (item_q.command) inside
      CMD_SET_INPUT: begin
        arg_ok   = (item_q.sub_mode <= MODE_PULLDOWN) && (item_q.latch_select <= LATCH_HIGH);
        status_d = !(usable_pin && arg_ok);
      end
      CMD_WRITE, CMD_BLINK: begin
        arg_ok   = (item_q.sub_mode <= 3'd1);
        status_d = !(usable_pin && arg_ok);
      end
      CMD_TICK, CMD_SAMPLE: status_d = 1'b0;
      default:              status_d = 1'b1;
    endcase
  end

  assign apply     = !status_d && (item_q.command <= CMD_BLINK);
  assign is_tick   = (item_q.command == CMD_TICK);
  assign is_sample = (item_q.command == CMD_SAMPLE);
  assign l250      = !item_q.blink_phase[0];
  assign l500      = !item_q.blink_phase[1];

  for (genvar p = 0; p < NUM_PINS; p++) begin : gen_pin
    logic [2:0]       mode_q, mode_d;
    logic [1:0]       lmode_q, lmode_d;
    logic             latched_q, latched_d;
    logic [CNT_W-1:0] cnt_q, cnt_d;
    logic             prev_q, prev_d;
    logic             drive_q, drive_d;
    logic             hit;
    logic             lvl;
    logic             target;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_sat;

    assign hit     = apply && (item_q.pin_index == PIN_W'(p));
    assign lvl     = item_q.pin_levels[p];
    assign target  = (lmode_q == LATCH_HIGH);
    assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
    assign cnt_sat = (cnt_inc > thr_q) ? thr_q : cnt_inc;

    always_comb begin
      mode_d    = mode_q;
      lmode_d   = lmode_q;
      latched_d = latched_q;
      cnt_d     = cnt_q;
      prev_d    = prev_q;
      drive_d   = drive_q;
      if (hit) begin
        case (item_q.command)
          CMD_SET_INPUT: begin
            mode_d    = item_q.sub_mode;
            lmode_d   = item_q.latch_select;
            latched_d = 1'b0;
            cnt_d     = '0;
            prev_d    = 1'b0;
          end
          CMD_WRITE: begin
            mode_d  = item_q.sub_mode[0] ? MODE_OUT_HIGH : MODE_OUT_LOW;
            drive_d = item_q.sub_mode[0];
          end
          CMD_BLINK: begin
            mode_d  = item_q.sub_mode[0] ? MODE_BLINK_500 : MODE_BLINK_250;
            drive_d = 1'b0;
          end
          default: mode_d = mode_q;
        endcase
      end
      if (is_tick && valid_q[p]) begin
        if (mode_q == MODE_BLINK_250) begin
          drive_d = l250;
        end else if (mode_q == MODE_BLINK_500) begin
          drive_d = l500;
        end
      end
      if (is_sample && valid_q[p] && (lmode_q != LATCH_NONE) && !latched_q &&
          (mode_q <= MODE_PULLDOWN)) begin
        if (lvl == target) begin
          if (prev_q == target) begin
            cnt_d = cnt_sat;
            if (cnt_sat >= thr_q) begin
              latched_d = 1'b1;
            end
          end else begin
            cnt_d = CNT_W'(1);
          end
        end else begin
          cnt_d = '0;
        end
        prev_d = lvl;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mode_q    <= MODE_FLOAT;
        lmode_q   <= LATCH_NONE;
        latched_q <= 1'b0;
        cnt_q     <= '0;
        prev_q    <= 1'b0;
        drive_q   <= 1'b0;
      end else if (ctl_i.exec) begin
        mode_q    <= mode_d;
        lmode_q   <= lmode_d;
        latched_q <= latched_d;
        cnt_q     <= cnt_d;
        prev_q    <= prev_d;
        drive_q   <= drive_d;
      end
    end

    assign oe_d[p] = (mode_d >= MODE_OUT_LOW);
    assign ol_d[p] = (mode_d >= MODE_OUT_LOW) && drive_d;
    assign pu_d[p] = (mode_d == MODE_PULLUP);
    assign pd_d[p] = (mode_d == MODE_PULLDOWN);
    assign la_d[p] = latched_d;
  end

  assign result_o = result_q;

endmodule

FILE: hw/rtl/gpio_mode_blink_latch_controller_unit.sv
// Top level of the GPIO mode, blink and latch controller.
// A transaction is taken at a clock edge with start high and busy low. busy is then
// high during the execution state, in which the per-pin state of all 40 pins updates
// in parallel; the following cycle shows the result on result_o with done_o high
// for exactly that one cycle. The receiver cannot stall, so the result must be
// captured then. A new start is taken in the done_o cycle, so a new transaction can
// be accepted while the previous result is shown.
// Configuration writes take effect at the write edge and belong in idle periods.
module gpio_mode_blink_latch_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  gpio_ctl_pkg::in_t              item_i,
  output logic                           done_o,
  output gpio_ctl_pkg::out_t             result_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [gpio_ctl_pkg::CFG_W-1:0] cfg_wdata_i
);
  import gpio_ctl_pkg::*;

  ctl_t ctl;

  gpio_ctl_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctl_o  (ctl)
  );

  gpio_ctl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

endmodule

FILE: hw/rtl/gpio_ctl_checker.sv
// Port-level assertions for the controller top level, with its bind.
module gpio_ctl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input gpio_ctl_pkg::out_t result_o
);
  import gpio_ctl_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("result strobe missing two cycles after accept");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_level_in_oe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.output_level_mask & ~result_o.output_enable_mask) == '0))
    else $error("driven level on a pin that is not an output");

  a_pull_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.pullup_mask & result_o.pulldown_mask) == '0) &&
               ((result_o.pullup_mask & result_o.output_enable_mask) == '0))
    else $error("pin reported in more than one mode");

endmodule

bind gpio_mode_blink_latch_controller_unit gpio_ctl_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
